// ----- hw/rtl/sacl_pkg.sv -----
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int MAX_SETS     = 256;
  localparam int WAYS         = 4;
  localparam int ADDR_WIDTH   = 32;
  localparam int OFFSET_BITS  = 2;
  localparam int DATA_W       = 32;
  localparam int TAG_W        = 30;
  localparam int CNT_W        = 32;
  localparam int LFSR_W       = 16;
  localparam int SET_W        = $clog2(MAX_SETS);
  localparam int WAY_W        = $clog2(WAYS);
  // Largest usable index width: floor(log2(MAX_SETS)).
  localparam int MAX_IDX_BITS = $clog2(MAX_SETS + 1) - 1;

  localparam int IDX_BITS_W   = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = LFSR_W;

  localparam logic [IDX_BITS_W-1:0] SET_BITS_RESET = IDX_BITS_W'(8);
  localparam logic [LFSR_W-1:0]     LFSR_RESET     = LFSR_W'(1);
  localparam logic [LFSR_W-1:0]     LFSR_TOGGLE    = 16'hB400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_INDEX_BITS = 2'd0,
    CFG_LFSR_SEED      = 2'd1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             start;
    logic             resolve;
    logic             clear;
    logic [SET_W-1:0] clear_row;
  } sacl_cmd_t;

endpackage

// ----- hw/rtl/set_associative_cache_lookup.sv -----
`timescale 1ns / 1ps

// Four-way set-associative word cache with pseudo-random replacement. Each input word
// carries a byte address and the memory word found there; each produces one result word
// with the cached data, a hit flag, the way used and saturating reference, hit and miss
// counts. The set row is read from the set memory in the cycle the word is accepted;
// then, once the result register is free, the tags are compared and a miss is written
// back into the same memory. No new word is accepted until that lookup resolves. The
// result is held in an output register and the next word is accepted while it waits.
// After reset a clearing pass sweeps the valid bits, one set per cycle through every
// set, during which no input word is accepted; configuration writes are taken at any
// time and should be made only while the cache is idle.
module set_associative_cache_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sacl_pkg::ADDR_WIDTH-1:0] addr_i,
  input  logic [sacl_pkg::DATA_W-1:0]     fill_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sacl_pkg::DATA_W-1:0]     read_data_o,
  output logic                            hit_o,
  output logic [sacl_pkg::WAY_W-1:0]      way_used_o,
  output logic [sacl_pkg::CNT_W-1:0]      ref_count_o,
  output logic [sacl_pkg::CNT_W-1:0]      hit_count_o,
  output logic [sacl_pkg::CNT_W-1:0]      miss_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sacl_pkg::*;

  sacl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sacl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .addr_i       (addr_i),
    .fill_data_i  (fill_data_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .way_used_o   (way_used_o),
    .ref_count_o  (ref_count_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

endmodule

// ----- hw/rtl/sacl_ctrl.sv -----
`timescale 1ns / 1ps

module sacl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sacl_pkg::sacl_cmd_t cmd_o
);
  import sacl_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE
  } state_e;

  state_e           state_q, state_d;
  logic [SET_W-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic             start, resolve;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign start       = in_valid_i && in_ready_o;
  // The result register must be free, or emptied in this cycle, before a lookup resolves.
  assign resolve     = (state_q == ST_RESOLVE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.start     = start;
  assign cmd_o.resolve   = resolve;
  assign cmd_o.clear     = (state_q == ST_CLEAR);
  assign cmd_o.clear_row = clr_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (clr_q == SET_W'(MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (resolve) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/sacl_datapath.sv -----
`timescale 1ns / 1ps

module sacl_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sacl_pkg::sacl_cmd_t            cmd_i,
  input  logic [sacl_pkg::ADDR_WIDTH-1:0] addr_i,
  input  logic [sacl_pkg::DATA_W-1:0]    fill_data_i,
  input  logic                           cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [sacl_pkg::DATA_W-1:0]    read_data_o,
  output logic                           hit_o,
  output logic [sacl_pkg::WAY_W-1:0]     way_used_o,
  output logic [sacl_pkg::CNT_W-1:0]     ref_count_o,
  output logic [sacl_pkg::CNT_W-1:0]     hit_count_o,
  output logic [sacl_pkg::CNT_W-1:0]     miss_count_o
);
  import sacl_pkg::*;

  // Set memories: one row per set, one element per way.
  logic [WAYS-1:0]   valid_mem [MAX_SETS];
  logic [TAG_W-1:0]  tag_mem   [MAX_SETS][WAYS];
  logic [DATA_W-1:0] word_mem  [MAX_SETS][WAYS];

  logic [IDX_BITS_W-1:0] set_bits_q;
  logic [LFSR_W-1:0]     lfsr_q;
  logic [CNT_W-1:0]      ref_q, hits_q, misses_q;

  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [DATA_W-1:0] fill_q;
  logic [WAYS-1:0]   rd_valid_q;
  logic [TAG_W-1:0]  rd_tag_q  [WAYS];
  logic [DATA_W-1:0] rd_word_q [WAYS];

  logic [DATA_W-1:0] read_data_q;
  logic              hit_q;
  logic [WAY_W-1:0]  way_q;

  logic [IDX_BITS_W-1:0] eff_bits;
  logic [SET_W:0]        set_span;
  logic [SET_W-1:0]      set_mask, set_c;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [TAG_W-1:0]      tag_c;

  logic [WAYS-1:0]   hit_vec;
  logic              any_hit, any_free;
  logic [WAY_W-1:0]  hit_way, free_way, way_sel;
  logic [LFSR_W-1:0] lfsr_nx, seed;
  logic [WAYS-1:0]   way_onehot;

  // Index width saturates at what the set memory can hold.
  assign eff_bits = (set_bits_q > IDX_BITS_W'(MAX_IDX_BITS)) ?
                    IDX_BITS_W'(MAX_IDX_BITS) : set_bits_q;
  assign set_span = (SET_W + 1)'(1) << eff_bits;
  assign set_mask = SET_W'(set_span - (SET_W + 1)'(1));
  assign set_c    = addr_i[OFFSET_BITS +: SET_W] & set_mask;
  assign shifted  = addr_i >> ((IDX_BITS_W + 1)'(eff_bits) + (IDX_BITS_W + 1)'(OFFSET_BITS));
  assign tag_c    = shifted[TAG_W-1:0];

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = rd_valid_q[w] && (rd_tag_q[w] == tag_q);
    end
    // Walk downward so the lowest matching or empty way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
        any_hit = 1'b1;
      end
      if (!rd_valid_q[w]) begin
        free_way = WAY_W'(w);
        any_free = 1'b1;
      end
    end
  end

  assign lfsr_nx = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TOGGLE : '0);
  assign way_sel = any_hit ? hit_way : (any_free ? free_way : lfsr_nx[WAY_W-1:0]);
  assign way_onehot = WAYS'(1) << way_sel;
  assign seed = (cfg_data_i == '0) ? LFSR_RESET : cfg_data_i;

  // Configuration, replacement generator and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= SET_BITS_RESET;
      lfsr_q     <= LFSR_RESET;
      ref_q      <= '0;
      hits_q     <= '0;
      misses_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SET_INDEX_BITS: set_bits_q <= cfg_data_i[IDX_BITS_W-1:0];
          CFG_LFSR_SEED:      lfsr_q     <= seed;
          default: ;
        endcase
      end
      if (cmd_i.resolve) begin
        ref_q <= (&ref_q) ? ref_q : ref_q + CNT_W'(1);
        if (any_hit) begin
          hits_q <= (&hits_q) ? hits_q : hits_q + CNT_W'(1);
        end else begin
          misses_q <= (&misses_q) ? misses_q : misses_q + CNT_W'(1);
          if (!any_free) begin
            lfsr_q <= lfsr_nx;
          end
        end
      end
    end
  end

  // Lookup registers and result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      set_q  <= set_c;
      tag_q  <= tag_c;
      fill_q <= fill_data_i;
    end
    if (cmd_i.resolve) begin
      read_data_q <= any_hit ? rd_word_q[hit_way] : fill_q;
      hit_q       <= any_hit;
      way_q       <= way_sel;
    end
  end

  // Valid memory: cleared row by row after reset, read on each lookup.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      valid_mem[cmd_i.clear_row] <= '0;
    end else if (cmd_i.resolve && !any_hit) begin
      valid_mem[set_q] <= rd_valid_q | way_onehot;
    end
    if (cmd_i.start) begin
      rd_valid_q <= valid_mem[set_c];
    end
  end

  // Tag and word memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve && !any_hit) begin
      tag_mem[set_q][way_sel]  <= tag_q;
      word_mem[set_q][way_sel] <= fill_q;
    end
    if (cmd_i.start) begin
      for (int w = 0; w < WAYS; w++) begin
        rd_tag_q[w]  <= tag_mem[set_c][w];
        rd_word_q[w] <= word_mem[set_c][w];
      end
    end
  end

  assign read_data_o  = read_data_q;
  assign hit_o        = hit_q;
  assign way_used_o   = way_q;
  assign ref_count_o  = ref_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sacl_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int POOL_SIZE      = 24;
  localparam int HOT_SETS       = 3;
  localparam int DRAIN_EVERY    = 150;
  localparam int ENTRIES        = MAX_SETS * WAYS;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN, OP_PACE} op_kind_e;

  typedef struct {
    op_kind_e                kind;
    logic [ADDR_WIDTH-1:0]   addr;
    logic [DATA_W-1:0]       fill;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    int                      send_idle;
    int                      recv_idle;
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic [CNT_W-1:0]  refs;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
  } lookup_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [ADDR_WIDTH-1:0] addr      = '0;
  logic [DATA_W-1:0]     fill_data = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  cfg_ready_o;
  logic [DATA_W-1:0]     read_data_o;
  logic                  hit_o;
  logic [WAY_W-1:0]      way_used_o;
  logic [CNT_W-1:0]      ref_count_o;
  logic [CNT_W-1:0]      hit_count_o;
  logic [CNT_W-1:0]      miss_count_o;

  // Shadow copy of the cache contents and configuration.
  logic                  line_valid [ENTRIES];
  logic [TAG_W-1:0]      line_tag   [ENTRIES];
  logic [DATA_W-1:0]     line_word  [ENTRIES];
  logic [LFSR_W-1:0]     victim_lfsr;
  logic [IDX_BITS_W-1:0] shadow_set_bits;
  logic [CNT_W-1:0]      refs_total;
  logic [CNT_W-1:0]      hits_total;
  logic [CNT_W-1:0]      misses_total;

  op_t                   pending_ops[$];
  lookup_t               expected_lookups[$];
  logic [ADDR_WIDTH-1:0] addr_pool [POOL_SIZE];
  logic [7:0]            hot_sets  [HOT_SETS];

  int send_idle     = 0;
  int recv_idle     = 0;
  int errors        = 0;
  int stall_cycles  = 0;
  int lookups_done  = 0;
  int hits_seen     = 0;
  int replacements  = 0;
  int cfg_writes    = 0;

  set_associative_cache_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .addr_i       (addr),
    .fill_data_i  (fill_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .way_used_o   (way_used_o),
    .ref_count_o  (ref_count_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  task automatic clear_cache_model();
    for (int e = 0; e < ENTRIES; e++) begin
      line_valid[e] = 1'b0;
      line_tag[e]   = '0;
      line_word[e]  = '0;
    end
    victim_lfsr     = LFSR_RESET;
    shadow_set_bits = SET_BITS_RESET;
    refs_total      = '0;
    hits_total      = '0;
    misses_total    = '0;
  endtask

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Computes the result of one lookup and updates the shadow cache.
  task automatic predict_lookup(input logic [ADDR_WIDTH-1:0] a, input logic [DATA_W-1:0] f);
    int          bits;
    int          base;
    int          way;
    logic        found;
    logic        placed;
    logic [31:0] set_no;
    logic [TAG_W-1:0] tag;
    lookup_t     want;
    bits   = (int'(shadow_set_bits) > MAX_IDX_BITS) ? MAX_IDX_BITS : int'(shadow_set_bits);
    set_no = (a >> OFFSET_BITS) & ((32'd1 << bits) - 32'd1);
    tag    = TAG_W'(a >> (bits + OFFSET_BITS));
    base   = int'(set_no) * WAYS;
    way    = 0;
    found  = 1'b0;
    placed = 1'b0;
    refs_total = bump(refs_total);
    // Every way is checked for a match before any fill is considered.
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      hits_total = bump(hits_total);
      hits_seen++;
    end else begin
      misses_total = bump(misses_total);
      for (int w = 0; w < WAYS; w++) begin
        if (!placed && !line_valid[base + w]) begin
          placed = 1'b1;
          way    = w;
        end
      end
      if (!placed) begin
        victim_lfsr = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? LFSR_TOGGLE : '0);
        way = int'(victim_lfsr % WAYS);
        replacements++;
      end
      line_valid[base + way] = 1'b1;
      line_tag[base + way]   = tag;
      line_word[base + way]  = f;
    end
    want.read_data = line_word[base + way];
    want.hit       = found;
    want.way       = WAY_W'(way);
    want.refs      = refs_total;
    want.hits      = hits_total;
    want.misses    = misses_total;
    expected_lookups.push_back(want);
    lookups_done++;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_writes++;
    case (idx)
      CFG_SET_INDEX_BITS: begin
        shadow_set_bits = d[IDX_BITS_W-1:0];
      end
      CFG_LFSR_SEED: begin
        // A zero seed would lock the generator, so it is taken as one.
        victim_lfsr = (d == '0) ? LFSR_W'(1) : d[LFSR_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // Driver: issues queued words and register writes, holding each until taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    op_t  head;
    logic nxt_in_valid;
    logic nxt_cfg_valid;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      clear_cache_model();
    end else begin
      nxt_in_valid  = in_valid;
      nxt_cfg_valid = cfg_valid;
      if (in_valid && in_ready_o) begin
        predict_lookup(addr, fill_data);
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready_o) begin
        apply_cfg(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid && pending_ops.size() > 0) begin
        head = pending_ops[0];
        case (head.kind)
          OP_PACE: begin
            send_idle = head.send_idle;
            recv_idle = head.recv_idle;
            void'(pending_ops.pop_front());
          end
          OP_DRAIN: begin
            if (expected_lookups.size() == 0) begin
              void'(pending_ops.pop_front());
            end
          end
          OP_CFG: begin
            // Registers change only once the cache has nothing in flight.
            if (expected_lookups.size() == 0) begin
              cfg_index     <= head.cfg_index;
              cfg_data      <= head.cfg_data;
              nxt_cfg_valid = 1'b1;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= send_idle) begin
              addr         <= head.addr;
              fill_data    <= head.fill;
              nxt_in_valid = 1'b1;
              void'(pending_ops.pop_front());
            end
          end
        endcase
      end
      in_valid  <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // Monitor: checks every accepted result word against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    lookup_t got;
    lookup_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got.read_data = read_data_o;
        got.hit       = hit_o;
        got.way       = way_used_o;
        got.refs      = ref_count_o;
        got.hits      = hit_count_o;
        got.misses    = miss_count_o;
        if (expected_lookups.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("result word with nothing expected: data=%h hit=%b way=%0d",
                     got.read_data, got.hit, got.way);
          end
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("lookup mismatch at %0t", $realtime);
              $display("  expected data=%h hit=%b way=%0d refs=%0d hits=%0d misses=%0d",
                       want.read_data, want.hit, want.way, want.refs, want.hits,
                       want.misses);
              $display("  actual   data=%h hit=%b way=%0d refs=%0d hits=%0d misses=%0d",
                       got.read_data, got.hit, got.way, got.refs, got.hits, got.misses);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_word(input logic [ADDR_WIDTH-1:0] a, input logic [DATA_W-1:0] f);
    op_t op;
    op = '{kind: OP_WORD, addr: a, fill: f, cfg_index: '0, cfg_data: '0,
           send_idle: 0, recv_idle: 0};
    pending_ops.push_back(op);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    op_t op;
    op = '{kind: OP_CFG, addr: '0, fill: '0, cfg_index: idx, cfg_data: d,
           send_idle: 0, recv_idle: 0};
    pending_ops.push_back(op);
  endtask

  task automatic push_marker(input op_kind_e kind, input int s_idle, input int r_idle);
    op_t op;
    op = '{kind: kind, addr: '0, fill: '0, cfg_index: '0, cfg_data: '0,
           send_idle: s_idle, recv_idle: r_idle};
    pending_ops.push_back(op);
  endtask

  // Index width with random upper bits, which the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] index_word(input logic [IDX_BITS_W-1:0] b);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom());
    w[IDX_BITS_W-1:0] = b;
    return w;
  endfunction

  // A burst of lookups, mostly over a small pool of addresses crowded into a few
  // sets, so that hits, fills of free ways and replacements all occur.
  // About half of the lower half of the pool carries over from the previous burst.
  task automatic random_burst(input int count);
    logic [ADDR_WIDTH-1:0] a;
    for (int k = 0; k < HOT_SETS; k++) hot_sets[k] = 8'($urandom());
    for (int p = 0; p < POOL_SIZE; p++) begin
      if (p >= POOL_SIZE / 2 || $urandom_range(1) == 1) begin
        a = $urandom();
        a[9:2] = hot_sets[$urandom_range(HOT_SETS - 1)];
        addr_pool[p] = a;
      end
    end
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: a = $urandom();
        2, 3, 4: a = addr_pool[$urandom_range(5)];
        default: a = addr_pool[$urandom_range(POOL_SIZE - 1)];
      endcase
      a[1:0] = 2'($urandom());
      push_word(a, $urandom());
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) push_marker(OP_DRAIN, 0, 0);
    end
  endtask

  initial begin : stimulus
    for (int p = 0; p < POOL_SIZE; p++) addr_pool[p] = $urandom();

    push_marker(OP_PACE, 12, 86);
    // Field extremes; the second and fourth words hit through a different offset.
    push_word(32'h0000_0000, 32'h0000_0000);
    push_word(32'h0000_0003, 32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFC, 32'h0000_0000);
    push_word(32'hAAAA_AAAA, 32'h5555_5555);
    push_word(32'h5555_5555, 32'hAAAA_AAAA);
    // Seven tags into one set: free ways first, then replacement.
    for (int t = 1; t <= 5; t++) push_word((t << 10) | (3 << 2), $urandom());
    for (int t = 1; t <= 5; t++) push_word((t << 10) | (3 << 2), $urandom());
    for (int t = 6; t <= 7; t++) push_word((t << 10) | (3 << 2), $urandom());
    // An index width beyond the set count, a zero seed, and unused indexes.
    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd15));
    push_cfg(CFG_LFSR_SEED, '0);
    push_cfg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
    push_cfg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
    push_word(32'h0000_0000, $urandom());
    push_word(32'hFFFF_FFFF, $urandom());
    push_word((3 << 10) | (3 << 2), $urandom());
    // With a single set, entries filled under the wider index are read again.
    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd0));
    push_word(32'h0000_0000, $urandom());
    push_word(32'h0000_0010, $urandom());

    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd8));
    push_cfg(CFG_LFSR_SEED, CFG_DATA_W'($urandom_range(1, 65535)));
    random_burst(400);
    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd0));
    push_cfg(CFG_LFSR_SEED, 16'hFFFF);
    random_burst(300);
    push_marker(OP_PACE, 86, 12);
    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd2));
    push_cfg(CFG_LFSR_SEED, CFG_DATA_W'($urandom_range(1, 65535)));
    random_burst(300);
    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd15));
    push_cfg(CFG_LFSR_SEED, '0);
    push_cfg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
    push_cfg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
    random_burst(300);
    push_marker(OP_PACE, 0, 0);
    push_cfg(CFG_SET_INDEX_BITS, index_word(4'd5));
    push_cfg(CFG_LFSR_SEED, CFG_DATA_W'($urandom_range(1, 65535)));
    random_burst(300);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || cfg_valid ||
           expected_lookups.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d lookups: %0d hits, %0d misses, %0d random replacements.",
             lookups_done, hits_seen, lookups_done - hits_seen, replacements);
    $display("Made %0d register writes over index widths 0 to 15 and three pacing mixes.",
             cfg_writes);
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
